// ===== rtl/lcd_pkg.sv =====
// Shared constants for the linear-or-circular deque: word width, default depth,
// operation codes and status codes.
// No dependencies.
package lcd_pkg;

    localparam int WORD_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

// ===== rtl/linear_or_circular_deque.sv =====
// Top level of the linear-or-circular deque: pointer control, mode register and
// result register around a rotating ring of storage cells. Depends on lcd_pkg, lcd_ring.
//
//  channel   direction  handshake          payload
//  input     in         in_valid/in_stall  opcode, value
//  result    out        out_valid/out_stall status, removed_word
//  config    in         cfg_we             cfg_data (mode)
//
// An accepted item waits for its result beat until its slot is at the tap: the store
// is a ring that turns one slot a cycle. A refused operation needs no slot and waits
// only for the result register to be free. If the result register is still stalled when the
// slot comes round, the item waits another full turn of the ring.
// Reset clears the pointers and sets circular mode; the store keeps no reset.
// A new item is taken while an earlier result beat still waits on out_stall.
module linear_or_circular_deque #(
    parameter int DEPTH = lcd_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic signed [lcd_pkg::WORD_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic signed [lcd_pkg::WORD_W-1:0]  removed_word
);
    import lcd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t            state_reg, state_next;
    logic              mode_reg, mode_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic              empty_reg, empty_next;
    logic              pend_access_reg, pend_access_next;
    logic              pend_write_reg, pend_write_next;
    logic [PTR_W-1:0]  pend_slot_reg, pend_slot_next;
    logic [1:0]        pend_status_reg, pend_status_next;
    logic [WORD_W-1:0] pend_value_reg, pend_value_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [WORD_W-1:0] removed_reg, removed_next;

    logic              accept;
    logic              circ;
    logic              full;
    logic [PTR_W-1:0]  tail_up;
    logic [PTR_W-1:0]  tail_down;
    logic [PTR_W-1:0]  head_up;
    logic [PTR_W-1:0]  head_down;
    logic              out_free;
    logic              hit;
    logic              done_now;
    logic [WORD_W-1:0] tap;
    logic [PTR_W-1:0]  phase;

    lcd_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (done_now && pend_write_reg),
        .wr_data (pend_value_reg),
        .tap     (tap),
        .phase   (phase)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign circ     = mode_reg;

    assign tail_up   = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
    assign tail_down = (tail_reg == '0) ? LAST : tail_reg - 1'b1;
    assign head_up   = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign head_down = (head_reg == '0) ? LAST : head_reg - 1'b1;
    assign full      = !empty_reg && (tail_up == head_reg);

    assign out_free = !out_valid_reg || !out_stall;
    assign hit      = (phase == pend_slot_reg);
    assign done_now = (state_reg == S_BUSY) && (!pend_access_reg || hit) && out_free;

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = cfg_we ? cfg_data : mode_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        empty_next       = empty_reg;
        pend_access_next = pend_access_reg;
        pend_write_next  = pend_write_reg;
        pend_slot_next   = pend_slot_reg;
        pend_status_next = pend_status_reg;
        pend_value_next  = pend_value_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        removed_next     = removed_reg;

        if (accept)
        begin
            state_next       = S_BUSY;
            pend_access_next = 1'b0;
            pend_write_next  = 1'b0;
            pend_slot_next   = '0;
            pend_status_next = ST_DONE;
            pend_value_next  = value;
            case (opcode)
                OP_PUSH_REAR:
                begin
                    if (empty_reg)
                    begin
                        head_next        = '0;
                        tail_next        = '0;
                        empty_next       = 1'b0;
                        pend_access_next = 1'b1;
                        pend_write_next  = 1'b1;
                    end
                    else if (full || (!circ && tail_reg == LAST))
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        tail_next        = tail_up;
                        pend_access_next = 1'b1;
                        pend_write_next  = 1'b1;
                        pend_slot_next   = tail_up;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty_reg)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pend_access_next = 1'b1;
                        pend_slot_next   = head_reg;
                        // In linear mode a pop at the last slot drains the whole queue.
                        if (head_reg == tail_reg || (!circ && head_reg == LAST))
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            head_next = head_up;
                        end
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (empty_reg)
                    begin
                        head_next        = '0;
                        tail_next        = '0;
                        empty_next       = 1'b0;
                        pend_access_next = 1'b1;
                        pend_write_next  = 1'b1;
                    end
                    else if (full || (!circ && head_reg == '0))
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        head_next        = head_down;
                        pend_access_next = 1'b1;
                        pend_write_next  = 1'b1;
                        pend_slot_next   = head_down;
                    end
                end
                default:
                begin
                    if (empty_reg)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pend_access_next = 1'b1;
                        pend_slot_next   = tail_reg;
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            tail_next = tail_down;
                        end
                    end
                end
            endcase
        end

        if (done_now)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            status_next    = pend_status_reg;
            removed_next   = (pend_access_reg && !pend_write_reg) ? tap : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= 1'b1;
            head_reg        <= '0;
            tail_reg        <= '0;
            empty_reg       <= 1'b1;
            pend_access_reg <= 1'b0;
            pend_write_reg  <= 1'b0;
            pend_slot_reg   <= '0;
            pend_status_reg <= ST_DONE;
            pend_value_reg  <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_DONE;
            removed_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            empty_reg       <= empty_next;
            pend_access_reg <= pend_access_next;
            pend_write_reg  <= pend_write_next;
            pend_slot_reg   <= pend_slot_next;
            pend_status_reg <= pend_status_next;
            pend_value_reg  <= pend_value_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            removed_reg     <= removed_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign removed_word = $signed(removed_reg);

endmodule

// ===== rtl/lcd_cell.sv =====
// One storage cell of the deque ring: holds one word and hands it on every cycle.
// Depends on lcd_pkg for the word width.
module lcd_cell (
    input  logic                      clk,
    input  logic [lcd_pkg::WORD_W-1:0] d_in,
    input  logic                      load,
    input  logic [lcd_pkg::WORD_W-1:0] load_data,
    output logic [lcd_pkg::WORD_W-1:0] q
);
    import lcd_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    assign word_next = load ? load_data : d_in;

    // The store is undefined until written, so the cell carries no reset.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

// ===== rtl/lcd_ring.sv =====
// Rotating ring of lcd_cell instances with a phase counter naming the slot at cell 0.
// Depends on lcd_pkg and lcd_cell.
module lcd_ring #(
    parameter int DEPTH = lcd_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [lcd_pkg::WORD_W-1:0]  wr_data,
    output logic [lcd_pkg::WORD_W-1:0]  tap,
    output logic [$clog2(DEPTH)-1:0]    phase
);
    import lcd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WORD_W-1:0] q [DEPTH];
    logic [PTR_W-1:0]  phase_reg;
    logic [PTR_W-1:0]  phase_next;

    // Cell k holds slot (phase + k) mod DEPTH. Words move one cell down each cycle,
    // and the word leaving cell 0 re-enters at the top, where a write replaces it.
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k == DEPTH - 1)
            begin : g_top
                lcd_cell u_cell (
                    .clk       (clk),
                    .d_in      (q[0]),
                    .load      (wr_en),
                    .load_data (wr_data),
                    .q         (q[k])
                );
            end
            else
            begin : g_mid
                lcd_cell u_cell (
                    .clk       (clk),
                    .d_in      (q[k+1]),
                    .load      (1'b0),
                    .load_data (wr_data),
                    .q         (q[k])
                );
            end
        end
    endgenerate

    assign phase_next = (phase_reg == LAST) ? '0 : phase_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    assign tap   = q[0];
    assign phase = phase_reg;

endmodule
